// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared property forms, sampled on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/msde_pkg.sv -----
// ---------------------------------------------------------------------------
// msde_pkg
// widths, codes and helpers for the mass-spring-damper euler step
// ---------------------------------------------------------------------------
package msde_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int MSDE_DIGIT_W = 4;
  localparam int PROD_W      = 2 * DATA_W - FRAC_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int IDX_W       = 4;
  localparam int UMASS_W     = 31;

  localparam logic [IDX_W-1:0] REG_STIFF  = 4'd0;
  localparam logic [IDX_W-1:0] REG_DAMP   = 4'd1;
  localparam logic [IDX_W-1:0] REG_INVM   = 4'd2;
  localparam logic [IDX_W-1:0] REG_GPOS   = 4'd3;
  localparam logic [IDX_W-1:0] REG_GVEL   = 4'd4;
  localparam logic [IDX_W-1:0] REG_STEP   = 4'd5;
  localparam logic [IDX_W-1:0] REG_OFFSET = 4'd6;
  localparam logic [IDX_W-1:0] REG_MPS    = 4'd7;

  localparam logic [UMASS_W-1:0] INVM_RST = 31'd65536;
  localparam logic [UMASS_W-1:0] STEP_RST = 31'd66;

  localparam logic [1:0] OP_FORCE = 2'd0;
  localparam logic [1:0] OP_VEL   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_HOLD  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_STORE,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    UOP_FORCE,
    UOP_GPOS,
    UOP_GVEL,
    UOP_INVM,
    UOP_STIFF,
    UOP_DAMP,
    UOP_NPOS,
    UOP_NVEL
  } uop_t;

  localparam logic signed [ACC_W-1:0] Q_MAX_E =
    $signed({{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] Q_MIN_E =
    $signed({{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});

  function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > Q_MAX_E) begin
      r = Q_MAX_E[DATA_W-1:0];
    end else if (v < Q_MIN_E) begin
      r = Q_MIN_E[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/msde_mul.sv -----
// ---------------------------------------------------------------------------
// msde_mul
// digit-serial signed multiplier, q16.16 product floored to PROD_W bits
// ---------------------------------------------------------------------------
module msde_mul import msde_pkg::*; #(
  parameter int DIGIT_W = MSDE_DIGIT_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     done,
  output logic signed [PROD_W-1:0] prod
);

  localparam int STEPS = DATA_W / DIGIT_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam int HI_W  = DATA_W + DIGIT_W + 1;
  localparam int PP_W  = DATA_W + DIGIT_W + 1;
  localparam int SUM_W = HI_W + 1;

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] a_r, a_nxt;
  logic signed [HI_W-1:0]   hi_r, hi_nxt;
  logic [DATA_W-1:0]        lo_r, lo_nxt;

  logic                     last;
  logic [DIGIT_W-1:0]       digit;
  logic signed [DIGIT_W:0]  d_ext;
  logic signed [PP_W-1:0]   pp;
  logic signed [SUM_W-1:0]  sum;
  logic [2*DATA_W-1:0]      full;

  assign last  = (cnt_r == CNT_W'(STEPS - 1));
  assign digit = lo_r[DIGIT_W-1:0];
  assign d_ext = last ? $signed({digit[DIGIT_W-1], digit}) : $signed({1'b0, digit});
  assign pp    = a_r * d_ext;
  assign sum   = {hi_r[HI_W-1], hi_r} + {{(SUM_W-PP_W){pp[PP_W-1]}}, pp};
  assign full  = {hi_r[DATA_W-1:0], lo_r};
  assign prod  = $signed(full[2*DATA_W-1:FRAC_W]);
  assign done  = done_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a;
      hi_nxt   = '0;
      lo_nxt   = b;
    end else if (busy_r) begin
      hi_nxt  = HI_W'(sum >>> DIGIT_W);
      lo_nxt  = {sum[DIGIT_W-1:0], lo_r[DATA_W-1:DIGIT_W]};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

endmodule

// ----- hw/rtl/mass_spring_damper_euler_step.sv -----
// A force word takes every product of the step, one after another, through the
// one digit-serial multiplier that all products pass through; a velocity word
// first scales its drive in the same multiplier, and clear and hold words use none.
// One word is worked on at a time, and the next is accepted while the previous
// result still waits in the output register.
// Registers are written through cfg_index/cfg_data, always ready; indexes past
// the eighth register are ignored.

// ---------------------------------------------------------------------------
// mass_spring_damper_euler_step
// forward euler step of a mass-spring-damper plant with state feedback, q16.16
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mass_spring_damper_euler_step import msde_pkg::*; #(
  parameter int DIGIT_W = MSDE_DIGIT_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic signed [DATA_W-1:0] in_drive_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_position_out,
  output logic signed [DATA_W-1:0] out_velocity_out,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  logic signed [DATA_W-1:0] stiff_r, damp_r, gain_pos_r, gain_vel_r, offset_r, mps_r;
  logic [UMASS_W-1:0]       inv_mass_r, step_r;

  state_t                   state_r, state_nxt;
  uop_t                     uop_r, uop_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DATA_W-1:0] t_r, t_nxt;
  logic signed [DATA_W-1:0] npos_r, npos_nxt;
  logic signed [DATA_W-1:0] pos_r, pos_nxt;
  logic signed [DATA_W-1:0] vel_r, vel_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_pos_r, out_pos_nxt;
  logic signed [DATA_W-1:0] out_vel_r, out_vel_nxt;

  logic                     mul_start;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic                     mul_done;
  logic signed [PROD_W-1:0] mul_prod;
  logic                     op_sub;
  logic                     acc_keep;
  logic signed [DATA_W-1:0] acc_init;
  logic signed [DATA_W-1:0] acc_sat;

  assign cfg_ready        = 1'b1;
  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_position_out = out_pos_r;
  assign out_velocity_out = out_vel_r;
  assign acc_sat          = sat_q(acc_r);

  msde_mul #(
    .DIGIT_W (DIGIT_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // operand routing per step of the sequence
  always_comb begin
    mul_a    = mps_r;
    mul_b    = t_r;
    op_sub   = 1'b0;
    acc_keep = 1'b0;
    acc_init = '0;
    case (uop_r)
      UOP_FORCE: begin
        mul_a = mps_r;
        mul_b = t_r;
      end
      UOP_GPOS: begin
        mul_a    = gain_pos_r;
        mul_b    = pos_r;
        op_sub   = 1'b1;
        acc_init = t_r;
      end
      UOP_GVEL: begin
        mul_a    = gain_vel_r;
        mul_b    = vel_r;
        op_sub   = 1'b1;
        acc_keep = 1'b1;
      end
      UOP_INVM: begin
        mul_a = $signed({1'b0, inv_mass_r});
        mul_b = t_r;
      end
      UOP_STIFF: begin
        mul_a    = stiff_r;
        mul_b    = pos_r;
        op_sub   = 1'b1;
        acc_keep = 1'b1;
      end
      UOP_DAMP: begin
        mul_a    = damp_r;
        mul_b    = vel_r;
        op_sub   = 1'b1;
        acc_keep = 1'b1;
      end
      UOP_NPOS: begin
        mul_a    = $signed({1'b0, step_r});
        mul_b    = vel_r;
        acc_init = pos_r;
      end
      UOP_NVEL: begin
        mul_a    = $signed({1'b0, step_r});
        mul_b    = t_r;
        acc_init = vel_r;
      end
      default: begin
        mul_a = mps_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    uop_nxt       = uop_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    npos_nxt      = npos_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_vel_nxt   = out_vel_r;
    mul_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          t_nxt = in_drive_value;
          case (in_op)
            OP_FORCE: begin
              uop_nxt   = UOP_GPOS;
              state_nxt = ST_LOAD;
            end
            OP_VEL: begin
              uop_nxt   = UOP_FORCE;
              state_nxt = ST_LOAD;
            end
            OP_CLEAR: begin
              pos_nxt   = '0;
              vel_nxt   = '0;
              state_nxt = ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_LOAD: begin
        mul_start = 1'b1;
        acc_nxt   = acc_keep ? acc_r : ACC_W'(acc_init);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          acc_nxt   = op_sub ? acc_r - ACC_W'(mul_prod) : acc_r + ACC_W'(mul_prod);
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        state_nxt = ST_LOAD;
        uop_nxt   = uop_t'(uop_r + 3'd1);
        case (uop_r)
          UOP_FORCE, UOP_GVEL, UOP_DAMP: begin
            t_nxt = acc_sat;
          end
          UOP_NPOS: begin
            npos_nxt = acc_sat;
          end
          UOP_NVEL: begin
            pos_nxt   = npos_r;
            vel_nxt   = acc_sat;
            state_nxt = ST_FIN;
          end
          default: begin
            t_nxt = t_r;
          end
        endcase
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = sat_q(ACC_W'(pos_r) + ACC_W'(offset_r));
          out_vel_nxt   = vel_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      uop_r       <= UOP_FORCE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      vel_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      uop_r       <= uop_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    t_r       <= t_nxt;
    npos_r    <= npos_nxt;
    out_pos_r <= out_pos_nxt;
    out_vel_r <= out_vel_nxt;
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r    <= '0;
      damp_r     <= '0;
      inv_mass_r <= INVM_RST;
      gain_pos_r <= '0;
      gain_vel_r <= '0;
      step_r     <= STEP_RST;
      offset_r   <= '0;
      mps_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STIFF:  stiff_r    <= $signed(cfg_data);
        REG_DAMP:   damp_r     <= $signed(cfg_data);
        REG_INVM:   inv_mass_r <= cfg_data[UMASS_W-1:0];
        REG_GPOS:   gain_pos_r <= $signed(cfg_data);
        REG_GVEL:   gain_vel_r <= $signed(cfg_data);
        REG_STEP:   step_r     <= cfg_data[UMASS_W-1:0];
        REG_OFFSET: offset_r   <= $signed(cfg_data);
        REG_MPS:    mps_r      <= $signed(cfg_data);
        default:    mps_r      <= mps_r;
      endcase
    end
  end

  `AST_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
  `AST_IMPLY(a_done_in_mul, mul_done, state_r == ST_MUL)
  `AST_NEXT(a_state_hold, state_r == ST_MUL, $stable(pos_r) && $stable(vel_r))

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// checks the mass-spring-damper euler step against a q16.16 plant model kept
// in step with every accepted word, under random idling and back-pressure
// ---------------------------------------------------------------------------
module testbench import msde_pkg::*; ();

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 4'd15;
  localparam logic [31:0] Q_TOP    = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_BOTTOM = 32'h8000_0000;
  localparam logic [31:0] Q_ONE    = 32'h0001_0000;
  localparam logic [31:0] Q_NEG1   = 32'hFFFF_FFFF;

  typedef struct {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
  } motion_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = OP_FORCE;
  logic signed [DATA_W-1:0] in_drive_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_position_out;
  logic signed [DATA_W-1:0] out_velocity_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  // plant model state and registers
  longint stiff_q, damp_q, invm_q, gpos_q, gvel_q, step_q, offset_q, mps_q;
  longint plant_pos, plant_vel;
  logic [31:0] next_regs [0:7];

  motion_t pending_motion [$];
  int mismatch_count = 0;
  int results_checked = 0;
  int words_sent = 0;
  int reg_writes = 0;
  int settings_count = 0;
  int cycle_count = 0;
  bit idle_en = 1'b1;
  int hold_len = 0;
  int hold_seq = 0;

  mass_spring_damper_euler_step dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_drive_value   (in_drive_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position_out (out_position_out),
    .out_velocity_out (out_velocity_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_motion.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, shifted down with floor rounding
  function automatic longint qprod(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> FRAC_W;
  endfunction

  function automatic void reset_plant();
    stiff_q = 0;
    damp_q = 0;
    invm_q = 65536;
    gpos_q = 0;
    gvel_q = 0;
    step_q = 66;
    offset_q = 0;
    mps_q = 0;
    plant_pos = 0;
    plant_vel = 0;
  endfunction

  function automatic void store_reg(input logic [IDX_W-1:0] idx, input logic [31:0] d);
    case (idx)
      REG_STIFF:  stiff_q = longint'($signed(d));
      REG_DAMP:   damp_q = longint'($signed(d));
      REG_INVM:   invm_q = longint'(d[30:0]);
      REG_GPOS:   gpos_q = longint'($signed(d));
      REG_GVEL:   gvel_q = longint'($signed(d));
      REG_STEP:   step_q = longint'(d[30:0]);
      REG_OFFSET: offset_q = longint'($signed(d));
      REG_MPS:    mps_q = longint'($signed(d));
      default: ;
    endcase
  endfunction

  function automatic void advance_plant(input logic [1:0] op, input logic [31:0] drv);
    longint force_q, ctrl, accel, npos, nvel;
    motion_t m;
    case (op)
      OP_CLEAR: begin
        plant_pos = 0;
        plant_vel = 0;
      end
      OP_HOLD: ;
      default: begin
        force_q = longint'($signed(drv));
        if (op == OP_VEL) force_q = clamp32(qprod(mps_q, force_q));
        ctrl = clamp32(force_q - qprod(gpos_q, plant_pos) - qprod(gvel_q, plant_vel));
        accel = clamp32(qprod(invm_q, ctrl) - qprod(stiff_q, plant_pos)
                        - qprod(damp_q, plant_vel));
        npos = clamp32(plant_pos + qprod(step_q, plant_vel));
        nvel = clamp32(plant_vel + qprod(step_q, accel));
        plant_pos = npos;
        plant_vel = nvel;
      end
    endcase
    m.position = 32'(clamp32(plant_pos + offset_q));
    m.velocity = 32'(plant_vel);
    pending_motion.push_back(m);
  endfunction

  function automatic logic [31:0] signed_within(input int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 5))
      0: return Q_TOP;
      1: return Q_BOTTOM;
      2: return '0;
      3: return Q_NEG1;
      4: return Q_ONE;
      default: return 32'd1;
    endcase
  endfunction

  function automatic logic [31:0] random_drive();
    case ($urandom_range(0, 9))
      0: return extreme_word();
      1, 2: return $urandom;
      default: return signed_within(64 << 16);
    endcase
  endfunction

  function automatic logic [1:0] random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_FORCE;
    if (r < 85) return OP_VEL;
    if (r < 93) return OP_CLEAR;
    return OP_HOLD;
  endfunction

  // drive one word, leaving valid high once it is taken
  task automatic send_word(input logic [1:0] op, input logic [31:0] drv);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_drive_value <= drv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_plant(op, drv);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    store_reg(idx, d);
    reg_writes++;
  endtask

  task automatic load_settings();
    for (int i = 0; i < 8; i++) write_reg(IDX_W'(i), next_regs[i]);
    if ($urandom_range(0, 2) == 0)
      write_reg(IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  task automatic roll_settings();
    case ($urandom_range(0, 4))
      0: for (int i = 0; i < 8; i++) next_regs[i] = $urandom;
      1: for (int i = 0; i < 8; i++) next_regs[i] = extreme_word();
      default: begin
        next_regs[REG_STIFF] = signed_within(40 << 16);
        next_regs[REG_DAMP] = signed_within(8 << 16);
        next_regs[REG_INVM] = $urandom_range(1, 4 << 16) | ($urandom_range(0, 1) << 31);
        next_regs[REG_GPOS] = signed_within(16 << 16);
        next_regs[REG_GVEL] = signed_within(8 << 16);
        next_regs[REG_STEP] = $urandom_range(1, 3277) | ($urandom_range(0, 1) << 31);
        next_regs[REG_OFFSET] = signed_within(200 << 16);
        next_regs[REG_MPS] = signed_within(500 << 16);
      end
    endcase
  endtask

  // result side: random stalls plus the long hold-off when asked
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    motion_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_motion.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: position %h velocity %h", out_position_out,
                   out_velocity_out);
      end else begin
        want = pending_motion.pop_front();
        results_checked++;
        if (out_position_out !== want.position || out_velocity_out !== want.velocity) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at word %0d: position exp %h got %h, velocity exp %h got %h",
                     results_checked, want.position, out_position_out, want.velocity,
                     out_velocity_out);
        end
      end
    end
  end

  task automatic test_defaults_after_reset();
    send_word(OP_FORCE, Q_TOP);
    send_word(OP_FORCE, Q_BOTTOM);
    send_word(OP_FORCE, '0);
    send_word(OP_FORCE, Q_NEG1);
    send_word(OP_HOLD, $urandom);
    send_word(OP_CLEAR, $urandom);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    next_regs[REG_STIFF] = Q_BOTTOM;
    next_regs[REG_DAMP] = Q_TOP;
    next_regs[REG_INVM] = Q_TOP;
    next_regs[REG_GPOS] = Q_BOTTOM;
    next_regs[REG_GVEL] = Q_TOP;
    next_regs[REG_STEP] = Q_TOP;
    next_regs[REG_OFFSET] = Q_TOP;
    next_regs[REG_MPS] = Q_TOP;
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    load_settings();
    send_word(OP_VEL, Q_TOP);
    send_word(OP_VEL, Q_BOTTOM);
    send_word(OP_FORCE, Q_TOP);
    send_word(OP_FORCE, Q_BOTTOM);
    send_word(OP_HOLD, Q_TOP);
    send_word(OP_CLEAR, Q_BOTTOM);
    send_word(OP_VEL, Q_NEG1);
    wait_drained();
    // top bit set on the unsigned registers leaves a zero mass and a zero step
    next_regs[REG_STIFF] = 2 << 16;
    next_regs[REG_DAMP] = Q_ONE;
    next_regs[REG_INVM] = Q_BOTTOM;
    next_regs[REG_GPOS] = Q_ONE;
    next_regs[REG_GVEL] = Q_NEG1;
    next_regs[REG_STEP] = Q_BOTTOM;
    next_regs[REG_OFFSET] = Q_BOTTOM;
    next_regs[REG_MPS] = 10 << 16;
    load_settings();
    send_word(OP_FORCE, 32'h0100_0000);
    send_word(OP_VEL, Q_ONE);
    send_word(OP_HOLD, '0);
    send_word(OP_CLEAR, Q_TOP);
    wait_drained();
    next_regs[REG_STIFF] = 4 << 16;
    next_regs[REG_DAMP] = 32'h0000_8000;
    next_regs[REG_INVM] = Q_ONE;
    next_regs[REG_GPOS] = Q_ONE;
    next_regs[REG_GVEL] = 32'h0000_4000;
    next_regs[REG_STEP] = 655;
    next_regs[REG_OFFSET] = 32'hFFF0_0000;
    next_regs[REG_MPS] = 100 << 16;
    load_settings();
    send_word(OP_VEL, Q_ONE);
    send_word(OP_VEL, Q_ONE);
    send_word(OP_FORCE, 5 << 16);
    send_word(OP_FORCE, -(5 << 16));
    send_word(OP_HOLD, $urandom);
    wait_drained();
  endtask

  task automatic test_random_phases(input int phases, input int words);
    for (int p = 0; p < phases; p++) begin
      roll_settings();
      load_settings();
      for (int n = 0; n < words; n++) send_word(random_op(), random_drive());
      wait_drained();
    end
  endtask

  task automatic test_output_backpressure();
    hold_len = 600;
    hold_seq++;
    @(posedge clk);
    for (int n = 0; n < 12; n++) send_word(random_op(), random_drive());
    wait_drained();
  endtask

  task automatic test_streaming_no_gaps();
    idle_en = 1'b0;
    roll_settings();
    load_settings();
    for (int n = 0; n < 60; n++) send_word(random_op(), random_drive());
    wait_drained();
  endtask

  initial begin
    reset_plant();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults_after_reset();
    test_register_extremes();
    test_random_phases(6, 100);
    test_output_backpressure();
    test_random_phases(6, 100);
    test_streaming_no_gaps();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d register writes over %0d settings",
             words_sent, results_checked, reg_writes, settings_count);
    $display("force, velocity, clear and hold words; extreme, zero and spare registers");
    if (mismatch_count == 0 && pending_motion.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_motion.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
